FILE: rtl/upd_pkg.sv
package upd_pkg;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam logic [7:0] PLUS_CHAR   = 8'h2B;
    localparam logic [7:0] MINUS_CHAR  = 8'h2D;
    localparam int         QUEUE_DEPTH = 4;
    localparam logic [4:0] HEX_NONE    = 5'd16;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_FIRST = 2'd2
    } phase_t;

    // One queued command: either a single word, or a literal '%' followed
    // by the data byte as the closing word of the string.
    typedef struct packed {
        logic       two;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            v = 5'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // Two-character base-16 parse with leading blank or sign allowed.
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] va;
        logic [4:0] vb;
        logic [7:0] v;
        va = hex_val(a);
        vb = hex_val(b);
        v  = 8'd0;
        if (!va[4]) begin
            if (!vb[4]) begin
                v = {va[3:0], vb[3:0]};
            end
            else begin
                v = {4'd0, va[3:0]};
            end
        end
        else if (!vb[4]) begin
            if (is_ws(a) || a == PLUS_CHAR) begin
                v = {4'd0, vb[3:0]};
            end
            else if (a == MINUS_CHAR) begin
                v = 8'd0 - {4'd0, vb[3:0]};
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/url_percent_decoder.sv
// Streaming URL percent decoder. Takes one text byte per cycle on the slave
// stream (tlast marks the end of a string) and gives decoded bytes on the
// master stream. "%xy" becomes one byte parsed in base 16; a '%' cut short
// by the end of the string is passed through as is, and a decoded zero
// closes the output string (tlast set) and drops the rest of that input
// string. Input runs at one word per cycle while tready is high; output
// runs at one word per cycle while m_tready is high, except that a literal
// '%' at the end of a string produces two words. A queue of QUEUE_DEPTH
// commands between the classifier and the output sequencer absorbs those
// extra words and output stalls; tready drops only while the queue is full.
// Each command is registered in the queue, then in the output register.
module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in;
    cmd_t q_out;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_out),
        .empty    (q_empty)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_out),
        .cmd_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: rtl/upd_front.sv
module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] first_reg;
    logic [7:0] first_next;
    logic       drop_reg;
    logic       drop_next;
    logic       want_push;
    logic       accept;
    logic [7:0] dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && want_push;
    assign dec      = decode_pair(first_reg, in_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            first_reg <= 8'd0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            drop_reg  <= drop_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        drop_next  = drop_reg;
        want_push  = 1'b0;
        q_cmd      = '{two: 1'b0, data: in_byte, last: in_last};
        if (accept)
        begin
            if (drop_reg)
            begin
                // discard the rest of a string cut off by a decoded zero
                phase_next = PH_IDLE;
                if (in_last)
                begin
                    drop_next = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        if (in_last)
                        begin
                            phase_next = PH_IDLE;
                            want_push  = 1'b1;
                            q_cmd.two  = 1'b1;
                        end
                        else
                        begin
                            first_next = in_byte;
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST:
                    begin
                        phase_next = PH_IDLE;
                        want_push  = 1'b1;
                        q_cmd.data = dec;
                        if (dec == 8'd0)
                        begin
                            q_cmd.last = 1'b1;
                            if (!in_last)
                            begin
                                drop_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_byte == PCT_CHAR && !in_last)
                        begin
                            phase_next = PH_PCT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            want_push  = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/upd_queue.sv
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

endmodule

FILE: rtl/upd_back.sv
module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       second_reg;
    logic       second_next;
    logic [7:0] second_byte_reg;
    logic [7:0] second_byte_next;
    logic       load;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign load      = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        last_reg        <= last_next;
        second_byte_reg <= second_byte_next;
    end

    always_comb
    begin
        valid_next       = valid_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        second_next      = second_reg;
        second_byte_next = second_byte_reg;
        cmd_pop          = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                // finish a literal '%' pair before taking the next command
                valid_next  = 1'b1;
                byte_next   = second_byte_reg;
                last_next   = 1'b1;
                second_next = 1'b0;
            end
            else if (cmd_valid)
            begin
                cmd_pop    = 1'b1;
                valid_next = 1'b1;
                if (cmd.two)
                begin
                    byte_next        = PCT_CHAR;
                    last_next        = 1'b0;
                    second_next      = 1'b1;
                    second_byte_next = cmd.data;
                end
                else
                begin
                    byte_next = cmd.data;
                    last_next = cmd.last;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

endmodule
